@@ hdl/yaz0_lz_decoder_macros.svh @@
// Assertion macros shared by the Yaz0 decoder RTL.
`ifndef YAZ0_LZ_DECODER_MACROS_SVH
`define YAZ0_LZ_DECODER_MACROS_SVH

// Same-cycle implication, checked on the rising clock outside reset.
`define YAZ0_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock outside reset.
`define YAZ0_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/yaz0_pkg.sv @@
// Package with the constants, codes and helpers of the Yaz0 decoder.
package yaz0_pkg;

   // Default sizes.
   localparam int unsigned HistoryDepth   = 4096;
   localparam int unsigned BytesPerResult = 8;

   // Header layout.
   localparam logic [4:0] HeaderLen = 5'h10;
   localparam logic [4:0] MagicLen  = 5'd4;
   localparam logic [4:0] SizeEnd   = 5'd8;

   // Back-reference encoding.
   localparam logic [8:0] LongLenBias  = 9'h12;
   localparam logic [8:0] ShortLenBias = 9'd2;

   // Configuration register indexes.
   localparam logic [0:0] CsrSkipCount = 1'b0;
   localparam logic [0:0] CsrOutLimit  = 1'b1;

   // Reason a stream ended.
   typedef enum logic [1:0] {
      END_SIZE  = 2'd0,
      END_LIMIT = 2'd1,
      END_SKIP  = 2'd2,
      END_MAGIC = 2'd3
   } end_status_type;

   // Expected magic byte at header positions zero to three.
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0: m = 8'h59;
         2'd1: m = 8'h61;
         2'd2: m = 8'h7A;
         default: m = 8'h30;
      endcase
      return m;
   endfunction

endpackage

@@ hdl/yaz0_hist_ram.sv @@
// History memory: one write port and one read port with registered read data.
module yaz0_hist_ram #(
   parameter int unsigned DEPTH = yaz0_pkg::HistoryDepth,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/yaz0_lz_decoder.sv @@
// Top level of the Yaz0 decoder: header parser, token decoder, copy engine and packer.
//
// The request channel takes one compressed byte per request; req_stream_start
// marks header byte zero and restarts the decoder at once. Decoded bytes come
// out on the response channel packed up to BYTES_PER_RESULT per response,
// earliest byte in bits 7:0. The last response of a request has rsp_run_last
// set, and rsp_stream_done with rsp_end_status on the response where the
// stream ended. Requests that emit nothing and end no stream give no response.
// Header, flag and reference bytes are taken in the run state; a header byte
// that ends the stream moves on to the flush state for its end response. A
// literal is decoded, then flushed. A back-reference is copied, then flushed,
// and is cut short when the stream ends inside it: the copy engine reads one
// history byte per cycle, unless the output stalls, from the single-port-read
// history memory, with write-to-read forwarding for distance one.
// The configuration registers are sampled when the header completes.
// Reset clears the control state and leaves the history memory undefined;
// references that reach before the stream start read as zero. When the
// receiver stalls, a full pack waits in the pack register and the copy
// engine holds until it drains; no request is taken until the current one
// has placed its last response in the response register.
module yaz0_lz_decoder #(
   parameter int unsigned HISTORY_DEPTH    = yaz0_pkg::HistoryDepth,
   parameter int unsigned BYTES_PER_RESULT = yaz0_pkg::BytesPerResult
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_src_byte,
   input  logic        req_stream_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_data,
   output logic [3:0]  rsp_out_count,
   output logic        rsp_run_last,
   output logic        rsp_stream_done,
   output logic [1:0]  rsp_end_status,
   input  logic        csr_write_en,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned HistAw = $clog2(HISTORY_DEPTH);
   localparam logic [3:0] PackFull = 4'(BYTES_PER_RESULT);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_COPY,
      ST_FLUSH
   } state_type;

   state_type          state_ff, state_in;
   logic               finished_ff, finished_in;
   logic [4:0]         hdr_idx_ff, hdr_idx_in;
   logic [31:0]        total_ff, total_in;
   logic [31:0]        produced_ff, produced_in;
   logic [7:0]         flag_bits_ff, flag_bits_in;
   logic [3:0]         flags_left_ff, flags_left_in;
   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         ref_first_ff, ref_first_in;
   logic [7:0]         ref_second_ff, ref_second_in;
   logic [31:0]        skip_left_ff, skip_left_in;
   logic [31:0]        budget_ff, budget_in;
   logic [HistAw-1:0]  hist_pos_ff, hist_pos_in;
   logic [31:0]        skip_count_ff, skip_count_in;
   logic [31:0]        out_limit_ff, out_limit_in;
   logic [8:0]         len_left_ff, len_left_in;
   logic               ended_ff, ended_in;
   yaz0_pkg::end_status_type status_ff, status_in;
   logic [63:0]        pack_data_ff, pack_data_in;
   logic [3:0]         pack_cnt_ff, pack_cnt_in;
   logic               fwd_ff, fwd_in;
   logic [7:0]         fwd_data_ff, fwd_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic [3:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_done_ff, rsp_done_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               wr_en;
   logic [HistAw-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic [HistAw-1:0]  rd_addr;
   logic [7:0]         rd_data;

   logic               req_fire;
   logic               out_free;
   logic               put_en;
   logic [7:0]         put_b;
   logic               put_stall;
   logic [12:0]        ref_dist;
   logic [7:0]         copy_b;
   logic               fin_e;
   logic [4:0]         hdr_e;
   logic [31:0]        total_e;
   logic               put_end;

   yaz0_hist_ram #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (HistAw)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_RUN);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Copy source byte, zero before stream start; forwarded if the previous cycle wrote its address.
   assign ref_dist = {1'b0, ref_first_ff[3:0], ref_second_ff} + 13'd1;
   assign copy_b   = ({19'd0, ref_dist} > produced_ff) ? 8'h00 :
                     (fwd_ff ? fwd_data_ff : rd_data);

   // A byte that must be emitted waits while a full pack cannot leave.
   assign put_stall = (skip_left_ff == 32'd0) && (pack_cnt_ff == PackFull) && !out_free;

   // Next-state logic.
   always_comb begin
      state_in      = state_ff;
      finished_in   = finished_ff;
      hdr_idx_in    = hdr_idx_ff;
      total_in      = total_ff;
      produced_in   = produced_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      phase_in      = phase_ff;
      ref_first_in  = ref_first_ff;
      ref_second_in = ref_second_ff;
      skip_left_in  = skip_left_ff;
      budget_in     = budget_ff;
      hist_pos_in   = hist_pos_ff;
      skip_count_in = skip_count_ff;
      out_limit_in  = out_limit_ff;
      len_left_in   = len_left_ff;
      ended_in      = ended_ff;
      status_in     = status_ff;
      pack_data_in  = pack_data_ff;
      pack_cnt_in   = pack_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      put_en        = 1'b0;
      put_b         = 8'h00;
      put_end       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = hist_pos_ff;
      wr_data       = 8'h00;
      fin_e         = req_stream_start ? 1'b0 : finished_ff;
      hdr_e         = req_stream_start ? 5'd0 : hdr_idx_ff;
      total_e       = req_stream_start ? 32'd0 : total_ff;

      // Configuration writes.
      if (csr_write_en) begin
         case (csr_index)
            yaz0_pkg::CsrSkipCount: skip_count_in = csr_wdata;
            yaz0_pkg::CsrOutLimit:  out_limit_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_RUN: begin
            if (req_fire) begin
               if (req_stream_start) begin
                  finished_in = 1'b0;
                  hdr_idx_in  = 5'd0;
                  total_in    = 32'd0;
               end
               if (fin_e) begin
                  // Idle stream: the byte is dropped.
               end else if (hdr_e < yaz0_pkg::HeaderLen) begin
                  // Header: magic, big-endian size, then ignored bytes.
                  hdr_idx_in = hdr_e + 5'd1;
                  if (hdr_e < yaz0_pkg::MagicLen &&
                      req_src_byte != yaz0_pkg::magic_byte(hdr_e[1:0])) begin
                     finished_in = 1'b1;
                     ended_in    = 1'b1;
                     status_in   = yaz0_pkg::END_MAGIC;
                     state_in    = ST_FLUSH;
                  end else begin
                     if (hdr_e >= yaz0_pkg::MagicLen && hdr_e < yaz0_pkg::SizeEnd) begin
                        total_in = {total_e[23:0], req_src_byte};
                     end
                     if (hdr_e == yaz0_pkg::HeaderLen - 5'd1) begin
                        skip_left_in  = skip_count_ff;
                        budget_in     = out_limit_ff;
                        produced_in   = 32'd0;
                        flags_left_in = 4'd0;
                        flag_bits_in  = 8'h00;
                        phase_in      = 2'd0;
                        if (out_limit_ff == 32'd0) begin
                           finished_in = 1'b1;
                           ended_in    = 1'b1;
                           status_in   = yaz0_pkg::END_LIMIT;
                           state_in    = ST_FLUSH;
                        end else if (skip_count_ff > total_in) begin
                           finished_in = 1'b1;
                           ended_in    = 1'b1;
                           status_in   = yaz0_pkg::END_SKIP;
                           state_in    = ST_FLUSH;
                        end else if (total_in == 32'd0) begin
                           finished_in = 1'b1;
                           ended_in    = 1'b1;
                           status_in   = yaz0_pkg::END_SIZE;
                           state_in    = ST_FLUSH;
                        end
                     end
                  end
               end else begin
                  // Body tokens.
                  case (phase_ff)
                     2'd0: begin
                        if (flags_left_ff == 4'd0) begin
                           flag_bits_in  = req_src_byte;
                           flags_left_in = 4'd8;
                        end else if (flag_bits_ff[7]) begin
                           put_en        = 1'b1;
                           put_b         = req_src_byte;
                           flag_bits_in  = {flag_bits_ff[6:0], 1'b0};
                           flags_left_in = flags_left_ff - 4'd1;
                           state_in      = ST_FLUSH;
                        end else begin
                           ref_first_in = req_src_byte;
                           phase_in     = 2'd1;
                        end
                     end
                     2'd1: begin
                        ref_second_in = req_src_byte;
                        if (ref_first_ff[7:4] != 4'd0) begin
                           len_left_in   = {5'd0, ref_first_ff[7:4]} + yaz0_pkg::ShortLenBias;
                           flag_bits_in  = {flag_bits_ff[6:0], 1'b0};
                           flags_left_in = flags_left_ff - 4'd1;
                           phase_in      = 2'd0;
                           state_in      = ST_COPY;
                        end else begin
                           phase_in = 2'd2;
                        end
                     end
                     default: begin
                        len_left_in   = {1'b0, req_src_byte} + yaz0_pkg::LongLenBias;
                        flag_bits_in  = {flag_bits_ff[6:0], 1'b0};
                        flags_left_in = flags_left_ff - 4'd1;
                        phase_in      = 2'd0;
                        state_in      = ST_COPY;
                     end
                  endcase
               end
            end
         end

         ST_COPY: begin
            // One history byte per cycle, unless the output stalls, until the length or the stream ends.
            if (!put_stall) begin
               put_en      = 1'b1;
               put_b       = copy_b;
               len_left_in = len_left_ff - 9'd1;
               if (len_left_ff == 9'd1) begin
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_FLUSH: begin
            // Last response of the request, if bytes wait or the stream ended; end flags if it ended.
            if (pack_cnt_ff == 4'd0 && !ended_ff) begin
               state_in = ST_RUN;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = pack_data_ff;
               rsp_count_in  = pack_cnt_ff;
               rsp_last_in   = 1'b1;
               rsp_done_in   = ended_ff;
               rsp_status_in = ended_ff ? status_ff : yaz0_pkg::END_SIZE;
               pack_data_in  = 64'd0;
               pack_cnt_in   = 4'd0;
               ended_in      = 1'b0;
               state_in      = ST_RUN;
            end
         end

         default: state_in = ST_RUN;
      endcase

      // Place one decoded byte: history write, counters, skip, limit and size.
      if (put_en) begin
         wr_en       = 1'b1;
         wr_addr     = hist_pos_ff;
         wr_data     = put_b;
         hist_pos_in = hist_pos_ff + HistAw'(1);
         produced_in = produced_ff + 32'd1;
         if (skip_left_ff != 32'd0) begin
            skip_left_in = skip_left_ff - 32'd1;
         end else begin
            if (pack_cnt_ff == PackFull) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = pack_data_ff;
               rsp_count_in  = pack_cnt_ff;
               rsp_last_in   = 1'b0;
               rsp_done_in   = 1'b0;
               rsp_status_in = yaz0_pkg::END_SIZE;
               pack_data_in  = {56'd0, put_b};
               pack_cnt_in   = 4'd1;
            end else begin
               pack_data_in[{pack_cnt_ff[2:0], 3'b000} +: 8] = put_b;
               pack_cnt_in = pack_cnt_ff + 4'd1;
            end
            budget_in = budget_ff - 32'd1;
            if (budget_ff == 32'd1) begin
               put_end   = 1'b1;
               status_in = yaz0_pkg::END_LIMIT;
            end
         end
         if (!put_end && produced_in == total_ff) begin
            put_end   = 1'b1;
            status_in = yaz0_pkg::END_SIZE;
         end
         if (put_end) begin
            finished_in = 1'b1;
            ended_in    = 1'b1;
            state_in    = ST_FLUSH;
         end
      end

      // Read the byte for the next copy step; forward when it is being written.
      rd_addr     = hist_pos_in - HistAw'({ref_first_in[3:0], ref_second_in}) - HistAw'(1);
      fwd_in      = wr_en && (wr_addr == rd_addr);
      fwd_data_in = wr_data;
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         finished_ff   <= 1'b1;
         hdr_idx_ff    <= 5'd0;
         total_ff      <= 32'd0;
         produced_ff   <= 32'd0;
         flag_bits_ff  <= 8'h00;
         flags_left_ff <= 4'd0;
         phase_ff      <= 2'd0;
         skip_left_ff  <= 32'd0;
         budget_ff     <= 32'd0;
         hist_pos_ff   <= '0;
         skip_count_ff <= 32'd0;
         out_limit_ff  <= 32'hFFFF_FFFF;
         len_left_ff   <= 9'd0;
         ended_ff      <= 1'b0;
         status_ff     <= yaz0_pkg::END_SIZE;
         pack_cnt_ff   <= 4'd0;
         pack_data_ff  <= 64'd0;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         finished_ff   <= finished_in;
         hdr_idx_ff    <= hdr_idx_in;
         total_ff      <= total_in;
         produced_ff   <= produced_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         phase_ff      <= phase_in;
         skip_left_ff  <= skip_left_in;
         budget_ff     <= budget_in;
         hist_pos_ff   <= hist_pos_in;
         skip_count_ff <= skip_count_in;
         out_limit_ff  <= out_limit_in;
         len_left_ff   <= len_left_in;
         ended_ff      <= ended_in;
         status_ff     <= status_in;
         pack_cnt_ff   <= pack_cnt_in;
         pack_data_ff  <= pack_data_in;
         fwd_ff        <= fwd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ref_first_ff  <= ref_first_in;
      ref_second_ff <= ref_second_in;
      fwd_data_ff   <= fwd_data_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_data    = rsp_data_ff;
   assign rsp_out_count   = rsp_count_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;
   assign rsp_end_status  = rsp_status_ff;

`include "yaz0_lz_decoder_macros.svh"

   // Only the last response of a request may be short.
   `YAZ0_ASSERT_IMP(a_full_pack, rsp_valid_ff && !rsp_last_ff, rsp_count_ff == PackFull, "short pack not last")
   // The end of a stream is reported on the last response of its request.
   `YAZ0_ASSERT_IMP(a_done_last, rsp_valid_ff && rsp_done_ff, rsp_last_ff, "stream end not on last response")
   // A status other than size reached comes only with the end flag.
   `YAZ0_ASSERT_IMP(a_status_done, rsp_valid_ff && !rsp_done_ff, rsp_status_ff == yaz0_pkg::END_SIZE, "status without end")
   // A copy always has bytes left to place.
   `YAZ0_ASSERT_IMP(a_copy_len, state_ff == ST_COPY, len_left_ff != 9'd0, "copy with zero length")

endmodule
